// ===== rtl/core/abpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio bucket peak tracker package
// Shared widths, command codes and register indexes of the peak tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package abpt_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd1;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RBKT_W   = 10;
  localparam int unsigned PEAK_W   = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned BKT_W    = 11;
  localparam int unsigned PROD_W   = COUNT_W + BKT_W;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0] EXPECTED_RST     = 32'd1;
  localparam logic [BKT_W-1:0]   BUCKET_COUNT_RST = 11'd1024;

  // Full scale in unsigned Q1.15
  localparam logic [PEAK_W-1:0] FULL_SCALE = 16'h8000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PCM     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/abpt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module abpt_ram #(
  parameter  int unsigned DATA_W = 16,
  parameter  int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/audio_bucket_peak_tracker.sv =====
// ----------------------------------------------------------------------------
// Audio bucket peak tracker
// Takes s16le mono PCM one byte per item and keeps the peak magnitude of each
// bucket of the stream in a RAM; read and restart commands share the channel.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid_i/in_ready_o| cmd_i, pcm_byte_i, read_bucket_i
//  out     | output    | out_valid_o/out_ready_i | peak_level_o
//  cfg     | input     | cfg_we_i, no wait    | cfg_index_i, cfg_wdata_i
//
// A low byte is only held; a high byte passes through accept with the index multiply,
// bit-serial division (skipped once the index has saturated), a RAM read and a
// write-back. A read passes through accept with the RAM read and a data cycle that
// waits for the output register. After reset and each restart item the RAM is zeroed
// one entry a cycle, while no item is accepted; configuration writes go on.
// A waiting result stalls only a following read, which holds in its data cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_bucket_peak_tracker #(
  parameter int unsigned MAX_BUCKETS = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input items
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [abpt_pkg::CMD_W-1:0]         cmd_i,
  input  wire logic [abpt_pkg::BYTE_W-1:0]        pcm_byte_i,
  input  wire logic [abpt_pkg::RBKT_W-1:0]        read_bucket_i,
  // Result items
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [abpt_pkg::PEAK_W-1:0]        peak_level_o,
  // Configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [abpt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [abpt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned QW    = abpt_pkg::BKT_W;
  localparam int unsigned DCW   = $clog2(QW);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_BUCKETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RD_DATA
  } state_e;

  state_e state_q, state_d;

  logic [abpt_pkg::COUNT_W-1:0] exp_q, exp_d;
  logic [abpt_pkg::BKT_W-1:0]   bc_q, bc_d;

  logic [abpt_pkg::COUNT_W-1:0] count_q, count_d;
  logic [abpt_pkg::BYTE_W-1:0]  held_q, held_d;
  logic                         phase_q, phase_d;
  logic [AW-1:0]                clr_q, clr_d;

  logic [abpt_pkg::PEAK_W-1:0]  mag_q, mag_d;
  logic [abpt_pkg::PROD_W-1:0]  rem_q, rem_d;
  logic [abpt_pkg::PROD_W-1:0]  ds_q, ds_d;
  logic [QW-1:0]                quo_q, quo_d;
  logic [DCW-1:0]               dcnt_q, dcnt_d;
  logic [abpt_pkg::BKT_W-1:0]   b_q, b_d;
  logic                         sat_q, sat_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic                         in_range_q, in_range_d;

  logic                         out_valid_q, out_valid_d;
  logic [abpt_pkg::PEAK_W-1:0]  peak_q, peak_d;

  // RAM port signals
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [abpt_pkg::PEAK_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [abpt_pkg::PEAK_W-1:0]  ram_rdata;

  logic                         in_fire;
  logic [abpt_pkg::BKT_W-1:0]   b_eff;
  logic [abpt_pkg::PEAK_W-1:0]  raw;
  logic [abpt_pkg::PEAK_W-1:0]  raw_mag;
  logic                         div_ge;
  logic [abpt_pkg::BKT_W-1:0]   b_m1;
  logic [abpt_pkg::BKT_W-1:0]   bucket;
  logic [31:0]                  bucket_ext;
  logic [31:0]                  rb_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Bucket count in use, clamped to 1..MAX_BUCKETS.
  always_comb begin
    if (bc_q == '0) begin
      b_eff = abpt_pkg::BKT_W'(1);
    end else if (32'(bc_q) > 32'(MAX_BUCKETS)) begin
      b_eff = abpt_pkg::BKT_W'(MAX_BUCKETS);
    end else begin
      b_eff = bc_q;
    end
  end

  assign raw     = {pcm_byte_i, held_q};
  // Two's complement negation also maps -32768 onto 32768.
  assign raw_mag = raw[abpt_pkg::PEAK_W-1] ? (~raw + 1'b1) : raw;

  assign div_ge     = (rem_q >= ds_q);
  assign b_m1       = b_q - 1'b1;
  assign bucket     = (sat_q || (quo_q >= b_m1)) ? b_m1 : quo_q;
  assign bucket_ext = 32'(bucket);
  assign rb_ext     = 32'(read_bucket_i);

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    bc_d        = bc_q;
    count_d     = count_q;
    held_d      = held_q;
    phase_d     = phase_q;
    clr_d       = clr_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    ds_d        = ds_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    b_d         = b_q;
    sat_d       = sat_q;
    addr_d      = addr_q;
    in_range_d  = in_range_q;
    out_valid_d = out_valid_q;
    peak_d      = peak_q;

    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = mag_q;
    ram_re    = 1'b0;
    ram_raddr = rb_ext[AW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        abpt_pkg::REG_EXPECTED:     exp_d = cfg_wdata_i;
        abpt_pkg::REG_BUCKET_COUNT: bc_d  = cfg_wdata_i[abpt_pkg::BKT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LAST_ENTRY) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            abpt_pkg::CMD_PCM: begin
              if (!phase_q) begin
                held_d  = pcm_byte_i;
                phase_d = 1'b1;
              end else begin
                phase_d = 1'b0;
                mag_d   = raw_mag;
                b_d     = b_eff;
                // Once the count reaches the expected total the quotient is at
                // least b, so the sample goes to the last bucket; a zero total
                // lands here too.
                sat_d   = (count_q >= exp_q);
                rem_d   = abpt_pkg::PROD_W'(count_q) * abpt_pkg::PROD_W'(b_eff);
                ds_d    = abpt_pkg::PROD_W'(exp_q) << (QW - 1);
                quo_d   = '0;
                dcnt_d  = DCW'(QW - 1);
                state_d = (count_q >= exp_q) ? ST_LOOKUP : ST_DIV;
              end
            end
            abpt_pkg::CMD_READ: begin
              ram_re     = 1'b1;
              in_range_d = ({1'b0, read_bucket_i} < b_eff);
              state_d    = ST_RD_DATA;
            end
            abpt_pkg::CMD_RESTART: begin
              count_d = '0;
              held_d  = '0;
              phase_d = 1'b0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end

      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (div_ge) begin
          rem_d = rem_q - ds_q;
        end
        quo_d = {quo_q[QW-2:0], div_ge};
        ds_d  = ds_q >> 1;
        if (dcnt_q == '0) begin
          state_d = ST_LOOKUP;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end

      ST_LOOKUP: begin
        ram_re    = 1'b1;
        ram_raddr = bucket_ext[AW-1:0];
        addr_d    = bucket_ext[AW-1:0];
        state_d   = ST_UPDATE;
      end

      ST_UPDATE: begin
        ram_we    = (mag_q > ram_rdata);
        ram_waddr = addr_q;
        ram_wdata = mag_q;
        if (!sat_q) begin
          count_d = count_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      ST_RD_DATA: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          peak_d      = in_range_q ? ram_rdata : '0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      exp_q       <= abpt_pkg::EXPECTED_RST;
      bc_q        <= abpt_pkg::BUCKET_COUNT_RST;
      count_q     <= '0;
      held_q      <= '0;
      phase_q     <= 1'b0;
      clr_q       <= '0;
      dcnt_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      bc_q        <= bc_d;
      count_q     <= count_d;
      held_q      <= held_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      dcnt_q      <= dcnt_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    rem_q      <= rem_d;
    ds_q       <= ds_d;
    quo_q      <= quo_d;
    b_q        <= b_d;
    addr_q     <= addr_d;
    in_range_q <= in_range_d;
    peak_q     <= peak_d;
  end

  assign out_valid_o  = out_valid_q;
  assign peak_level_o = peak_q;

  abpt_ram #(
    .DATA_W (abpt_pkg::PEAK_W),
    .DEPTH  (MAX_BUCKETS)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A new result is only loaded from the read data cycle.
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RD_DATA))
    else $error("result appeared outside a read");

  // Below saturation the divider quotient always selects a bucket in use.
  a_quo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && !sat_q) |-> (quo_q < b_q))
    else $error("bucket quotient out of range");

  // The clearing pass leaves only after sweeping the last entry.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q == ST_CLEAR)) |-> ($past(clr_q) == LAST_ENTRY))
    else $error("clearing pass ended early");

  // Stored peaks never exceed full scale.
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (peak_q <= abpt_pkg::FULL_SCALE))
    else $error("peak above full scale");

endmodule

`default_nettype wire
